// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Sync frame receiver package
// Shared constants, the result record and the byte-wide CRC-16 update used by
// the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int FRAME_BYTES_DEF = 10;

   localparam logic [15:0] TIMEOUT_RESET = 16'd250;

   localparam logic [7:0]  HDR_FIRST   = 8'hAA;
   localparam logic [7:0]  HDR_SECOND  = 8'h55;
   localparam logic [7:0]  REJECT_CMD  = 8'hFF;
   localparam logic [7:0]  ACK_CMD     = 8'h81;
   localparam logic [7:0]  POLL_CMD    = 8'h02;
   localparam logic [7:0]  POLL_ID_SUB = 8'h01;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   // Result status codes.
   localparam logic [1:0] ST_GOOD    = 2'd0;
   localparam logic [1:0] ST_CRC_ERR = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   // Frame classification codes.
   localparam logic [1:0] KIND_OTHER     = 2'd0;
   localparam logic [1:0] KIND_POLL_ID   = 2'd1;
   localparam logic [1:0] KIND_POLL_DATA = 2'd2;
   localparam logic [1:0] KIND_ACK       = 2'd3;

   // Input item kinds carried on tuser.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic [7:0] sub_byte;
      logic [7:0] func_byte;
      logic [1:0] frame_kind;
      logic [1:0] status;
   } result_type;

   // Reflected CRC-16 update over one byte, least significant bit first.
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc_val,
                                              input logic [7:0]  data_val);
      logic [15:0] c;
      c = crc_val ^ {8'h00, data_val};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/sync_frame_receiver_crc16.sv -----
// ----------------------------------------------------------------------------
// Sync frame receiver with CRC-16 check
// rsp_tvalid rises once the input item that completes, rejects or times out a
// frame has moved through the input register and the deframer into the
// result register. Throughput is limited by the single deframer stage:
// one input item per cycle while the result side keeps up.
// Reset: synchronous and active high; the block returns to header hunting and
// the timeout register returns to 250 ticks.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc16 #(
   parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] cmd: 0 received byte, 1 timer tick
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] status, [3:2] frame_kind,
                                    // [11:4] func_byte, [19:12] sub_byte,
                                    // [23:20] zero
   // Timeout register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   // The input register holds one item; it moves into the deframer whenever the
   // result register is empty or its contents are being taken in the same
   // cycle. A fresh item is accepted as the held one moves on, so the block
   // streams one transfer per cycle while the result side keeps up.

   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   sfr_pkg::result_type rsp_data_ff;
   logic [15:0] timeout_ff;

   logic                advance;
   logic                step;
   logic                res_valid;
   sfr_pkg::result_type res;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = advance ? (step && res_valid) : rsp_valid_ff;
   end

   sfr_deframer #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_deframer (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .cmd           (in_cmd_ff),
      .rx_byte       (in_byte_ff),
      .timeout_ticks (timeout_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= sfr_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (step && res_valid && advance) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_data_ff};

endmodule

// ----- rtl/sfr_deframer.sv -----
// ----------------------------------------------------------------------------
// Sync frame receiver deframer
// Header hunt, frame collection, CRC check, classification and timeout, one
// input item per enabled cycle.
// ----------------------------------------------------------------------------
module sfr_deframer #(
   parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 cmd,
   input  logic [7:0]           rx_byte,
   input  logic [15:0]          timeout_ticks,
   output logic                 res_valid,
   output sfr_pkg::result_type  res
);

   localparam logic [1:0] PH_SEARCH  = 2'd0;
   localparam logic [1:0] PH_GOT_AA  = 2'd1;
   localparam logic [1:0] PH_COLLECT = 2'd2;

   localparam logic [4:0] CRC_LAST_IDX = 5'(FRAME_BYTES - 3);
   localparam logic [4:0] CRC_LOW_IDX  = 5'(FRAME_BYTES - 2);
   localparam logic [4:0] LAST_IDX     = 5'(FRAME_BYTES - 1);
   localparam logic [3:0] FIRST_IDX    = 4'd2;
   localparam logic [3:0] FUNC_IDX     = 4'd3;
   localparam logic [3:0] SUB_IDX      = 4'd4;
   localparam logic [3:0] REJECT_IDX   = 4'd6;

   logic [1:0]  phase_ff,  phase_in;
   logic [3:0]  idx_ff,    idx_in;
   logic [15:0] crc_ff,    crc_in;
   logic [7:0]  func_ff,   func_in;
   logic [7:0]  sub_ff,    sub_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] idle_ff,   idle_in;

   logic [15:0] crc_upd;
   logic [15:0] crc_cur;
   logic [15:0] idle_inc;
   logic [15:0] limit;
   logic [7:0]  func_new;
   logic [7:0]  sub_new;
   logic [7:0]  lo_new;
   logic        feed;
   logic        complete;
   logic        crc_ok;
   logic [1:0]  kind;

   always_comb begin
      crc_upd  = sfr_pkg::crc16_feed(crc_ff, rx_byte);
      feed     = (idx_ff >= FIRST_IDX) && ({1'b0, idx_ff} <= CRC_LAST_IDX);
      crc_cur  = feed ? crc_upd : crc_ff;
      func_new = (idx_ff == FUNC_IDX) ? rx_byte : func_ff;
      sub_new  = (idx_ff == SUB_IDX) ? rx_byte : sub_ff;
      lo_new   = ({1'b0, idx_ff} == CRC_LOW_IDX) ? rx_byte : crc_lo_ff;
      complete = {1'b0, idx_ff} >= LAST_IDX;
      crc_ok   = (lo_new == crc_cur[7:0]) && (rx_byte == crc_cur[15:8]);
      idle_inc = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      limit    = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;

      if (func_new == sfr_pkg::ACK_CMD) begin
         kind = sfr_pkg::KIND_ACK;
      end else if (func_new == sfr_pkg::POLL_CMD) begin
         kind = (sub_new == sfr_pkg::POLL_ID_SUB) ? sfr_pkg::KIND_POLL_ID
                                                   : sfr_pkg::KIND_POLL_DATA;
      end else begin
         kind = sfr_pkg::KIND_OTHER;
      end

      phase_in       = phase_ff;
      idx_in         = idx_ff;
      crc_in         = crc_ff;
      func_in        = func_ff;
      sub_in         = sub_ff;
      crc_lo_in      = crc_lo_ff;
      idle_in        = idle_ff;
      res_valid      = 1'b0;
      res.status     = sfr_pkg::ST_GOOD;
      res.frame_kind = sfr_pkg::KIND_OTHER;
      res.func_byte  = func_ff;
      res.sub_byte   = sub_ff;

      if (step) begin
         if (cmd == sfr_pkg::CMD_TICK) begin
            // Ticks only count while a frame is being collected.
            if (phase_ff == PH_COLLECT) begin
               idle_in = idle_inc;
               if (idle_inc >= limit) begin
                  res_valid  = 1'b1;
                  res.status = sfr_pkg::ST_TIMEOUT;
                  phase_in   = PH_SEARCH;
                  idx_in     = 4'd0;
                  idle_in    = 16'd0;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_GOT_AA: begin
                  if (rx_byte == sfr_pkg::HDR_SECOND) begin
                     phase_in  = PH_COLLECT;
                     idx_in    = FIRST_IDX;
                     crc_in    = sfr_pkg::CRC_INIT;
                     func_in   = 8'h00;
                     sub_in    = 8'h00;
                     crc_lo_in = 8'h00;
                     idle_in   = 16'd0;
                  end else if (rx_byte != sfr_pkg::HDR_FIRST) begin
                     phase_in = PH_SEARCH;
                  end
               end
               PH_COLLECT: begin
                  crc_in        = crc_cur;
                  func_in       = func_new;
                  sub_in        = sub_new;
                  crc_lo_in     = lo_new;
                  idx_in        = idx_ff + 4'd1;
                  res.func_byte = func_new;
                  res.sub_byte  = sub_new;
                  if ((idx_ff == REJECT_IDX) && (func_new == sfr_pkg::REJECT_CMD)) begin
                     res_valid  = 1'b1;
                     res.status = sfr_pkg::ST_REJECT;
                  end else if (complete) begin
                     res_valid = 1'b1;
                     if (!crc_ok) begin
                        res.status = sfr_pkg::ST_CRC_ERR;
                     end else begin
                        res.status     = sfr_pkg::ST_GOOD;
                        res.frame_kind = kind;
                     end
                  end
                  if (res_valid) begin
                     phase_in = PH_SEARCH;
                     idx_in   = 4'd0;
                     idle_in  = 16'd0;
                  end
               end
               default: begin
                  // Searching; the unused phase code behaves the same way.
                  phase_in = (rx_byte == sfr_pkg::HDR_FIRST) ? PH_GOT_AA : PH_SEARCH;
                  idle_in  = 16'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         idx_ff    <= 4'd0;
         crc_ff    <= sfr_pkg::CRC_INIT;
         func_ff   <= 8'h00;
         sub_ff    <= 8'h00;
         crc_lo_ff <= 8'h00;
         idle_ff   <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         crc_ff    <= crc_in;
         func_ff   <= func_in;
         sub_ff    <= sub_in;
         crc_lo_ff <= crc_lo_in;
         idle_ff   <= idle_in;
      end
   end

endmodule
